// ===== design/afp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afp_pkg
// Shared types and constants of the attitude frame packer.
// ----------------------------------------------------------------------------
package afp_pkg;

  localparam int unsigned ANGLE_W   = 32;
  localparam int unsigned PROD_W    = 42;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned IDX_W     = 5;

  localparam logic [BYTE_W-1:0]   FRAME_HEAD  = 8'hFF;
  localparam logic [BYTE_W-1:0]   FRAME_LEN   = 8'd13;
  localparam logic [BYTE_W-1:0]   FRAME_ZERO  = 8'd0;
  localparam logic [PROD_W-1:0]   ANGLE_SCALE = 42'd1000;

  localparam logic [IDX_W-1:0] IDX_HEAD  = 5'd0;
  localparam logic [IDX_W-1:0] IDX_DEST  = 5'd1;
  localparam logic [IDX_W-1:0] IDX_ID    = 5'd2;
  localparam logic [IDX_W-1:0] IDX_LEN   = 5'd3;
  localparam logic [IDX_W-1:0] IDX_ZERO  = 5'd4;
  localparam logic [IDX_W-1:0] IDX_DATA  = 5'd5;
  localparam logic [IDX_W-1:0] IDX_SUM   = 5'd17;
  localparam logic [IDX_W-1:0] IDX_ADD   = 5'd18;

  localparam logic REG_DEST_ADDR = 1'b0;
  localparam logic REG_FRAME_ID  = 1'b1;

  typedef struct packed {
    logic [ANGLE_W-1:0] roll;
    logic [ANGLE_W-1:0] pitch;
    logic [ANGLE_W-1:0] yaw;
  } afp_sample_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_id;
    logic [BYTE_W-1:0] dest_addr;
  } afp_cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } afp_qstat_t;

endpackage
`default_nettype wire

// ===== design/afp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afp_front
// Accepts samples, scales each angle by 1000/2^16 and truncates toward zero.
// ----------------------------------------------------------------------------
module afp_front import afp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire afp_sample_t in_sample,
  input  wire afp_qstat_t  q_stat,
  output logic             push,
  output afp_sample_t      push_data
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [PROD_W-1:0] prod_r   [3];
  logic [PROD_W-1:0] prod_nxt [3];
  logic [ANGLE_W-1:0] raw     [3];
  logic [ANGLE_W-1:0] scaled  [3];
  logic              in_fire;

  assign raw[0] = in_sample.yaw;
  assign raw[1] = in_sample.pitch;
  assign raw[2] = in_sample.roll;

  assign push      = s1_valid_r && !q_stat.full;
  assign in_tready = !s1_valid_r || !q_stat.full;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    logic [PROD_W-1:0] adj;
    for (int k = 0; k < 3; k++) begin
      prod_nxt[k] = PROD_W'($signed({{(PROD_W-ANGLE_W){raw[k][ANGLE_W-1]}}, raw[k]})
                    * $signed(ANGLE_SCALE));
    end
    for (int k = 0; k < 3; k++) begin
      adj = prod_r[k] + {{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{prod_r[k][PROD_W-1]}}};
      scaled[k] = {{(ANGLE_W-(PROD_W-FRAC_W)){adj[PROD_W-1]}}, adj[PROD_W-1:FRAC_W]};
    end
  end

  assign push_data.yaw   = scaled[0];
  assign push_data.pitch = scaled[1];
  assign push_data.roll  = scaled[2];

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (push) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/afp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afp_queue
// Short queue of scaled samples between the front and the back.
// ----------------------------------------------------------------------------
module afp_queue import afp_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire afp_sample_t push_data,
  input  wire logic        pop,
  output afp_sample_t      head,
  output afp_qstat_t       q_stat
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  afp_sample_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/afp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afp_back
// Serializes one queued sample into a 19-byte frame with both checks.
// ----------------------------------------------------------------------------
module afp_back import afp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire afp_qstat_t  q_stat,
  input  wire afp_sample_t head,
  input  wire afp_cfg_t    cfg,
  output logic             pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [BYTE_W-1:0] out_tdata,
  output logic             out_tlast
);

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] add_r, add_nxt;
  logic [3:0]        data_k;
  logic              out_fire;

  assign out_tvalid = !q_stat.empty;
  assign out_tlast  = (idx_r == IDX_ADD);
  assign out_fire   = out_tvalid && out_tready;
  assign pop        = out_fire && out_tlast;
  assign data_k     = 4'(idx_r - IDX_DATA);

  always_comb begin
    unique case (idx_r)
      IDX_HEAD: out_tdata = FRAME_HEAD;
      IDX_DEST: out_tdata = cfg.dest_addr;
      IDX_ID:   out_tdata = cfg.frame_id;
      IDX_LEN:  out_tdata = FRAME_LEN;
      IDX_ZERO: out_tdata = FRAME_ZERO;
      IDX_SUM:  out_tdata = sum_r;
      IDX_ADD:  out_tdata = add_r;
      default:  out_tdata = head[{data_k, 3'b000} +: BYTE_W];
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    sum_nxt = sum_r;
    add_nxt = add_r;
    if (out_fire) begin
      if (out_tlast) begin
        idx_nxt = IDX_HEAD;
        sum_nxt = '0;
        add_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r < IDX_SUM) begin
          sum_nxt = sum_r + out_tdata;
          if (idx_r >= IDX_LEN) begin
            add_nxt = add_r + sum_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= IDX_HEAD;
      sum_r <= '0;
      add_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      sum_r <= sum_nxt;
      add_r <= add_nxt;
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (idx_r == IDX_HEAD) && (sum_r == '0) && (add_r == '0))
    else $error("frame state not cleared after last byte");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(idx_r) && $stable(sum_r) && $stable(add_r))
    else $error("frame state moved during stall");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_ADD)
    else $error("byte index out of range");

  a_idle_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> (idx_r == IDX_HEAD))
    else $error("frame in progress with empty queue");

endmodule
`default_nettype wire

// ===== design/attitude_frame_packer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// attitude_frame_packer_core
// Scales a yaw/pitch/roll sample and sends it as a 19-byte checked frame.
// ----------------------------------------------------------------------------
// A taken sample is registered in the front, then written into the queue.
// One frame byte per cycle while a sample is queued and out_tready is high.
// The byte-serial back end sets the sample rate; the queue holds up to QUEUE_DEPTH
// scaled samples plus one in the front so input and output stall independently.
// Reset clears dest_addr and frame_id to 0 and empties front, queue and back.
module attitude_frame_packer_core import afp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // yaw_angle[31:0], pitch_angle[63:32], roll_angle[95:64]
  input  wire logic [95:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // frame_byte[7:0]
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  afp_cfg_t    cfg_r, cfg_nxt;
  afp_sample_t in_sample;
  afp_sample_t push_data;
  afp_sample_t head;
  afp_qstat_t  q_stat;
  logic        push;
  logic        pop;
  logic        cfg_wr;

  assign in_sample  = afp_sample_t'(in_tdata);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_DEST_ADDR: cfg_nxt.dest_addr = cfg_pwdata[7:0];
        REG_FRAME_ID:  cfg_nxt.frame_id  = cfg_pwdata[7:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_DEST_ADDR: cfg_prdata = {24'd0, cfg_r.dest_addr};
      REG_FRAME_ID:  cfg_prdata = {24'd0, cfg_r.frame_id};
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  afp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample (in_sample),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  afp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  afp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .cfg        (cfg_r),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== tb/sv/attitude_frame_packer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attitude_frame_packer_core_tb
// Self-checking bench for the attitude frame packer. Yaw/pitch/roll samples are
// streamed in, every frame byte on the output stream is compared with a frame
// built locally from the sample and the shadowed address/id registers. Random
// stalls on both sides vary across phases, and the registers are rewritten and
// read back between phases.
// ----------------------------------------------------------------------------
module attitude_frame_packer_core_tb;
  import afp_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 105;
  localparam int unsigned FRAME_BYTES = 19;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  afp_sample_t sample_q[$];
  frame_byte_t frame_bytes_q[$];
  frame_byte_t want_byte;
  logic [7:0]  dest_addr_shadow = '0;
  logic [7:0]  frame_id_shadow = '0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          errors = 0;
  int          frames_accepted = 0;
  int          bytes_checked = 0;
  int          stall_cycles = 0;

  attitude_frame_packer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // angle * 1000 / 2^16, truncated toward zero
  function automatic logic [31:0] scale_milli(logic [31:0] raw);
    longint angle;
    longint prod;
    angle = longint'(signed'(raw));
    prod = angle * 1000;
    return 32'(prod / 65536);
  endfunction

  function automatic void pack_frame(afp_sample_t s);
    logic [7:0]  bytes [FRAME_BYTES];
    logic [31:0] words [3];
    logic [7:0]  run_sum;
    logic [7:0]  add_check;
    bytes[0] = FRAME_HEAD;
    bytes[1] = dest_addr_shadow;
    bytes[2] = frame_id_shadow;
    bytes[3] = FRAME_LEN;
    bytes[4] = FRAME_ZERO;
    words[0] = scale_milli(s.yaw);
    words[1] = scale_milli(s.pitch);
    words[2] = scale_milli(s.roll);
    for (int w = 0; w < 3; w++) begin
      for (int b = 0; b < 4; b++) begin
        bytes[5 + 4*w + b] = words[w][8*b +: 8];
      end
    end
    run_sum = '0;
    for (int i = 0; i < 4; i++) begin
      run_sum += bytes[i];
    end
    add_check = run_sum;
    for (int i = 4; i < 17; i++) begin
      run_sum += bytes[i];
      add_check += run_sum;
    end
    bytes[17] = run_sum;
    bytes[18] = add_check;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      frame_bytes_q.push_back('{data: bytes[i], last: (i == FRAME_BYTES - 1)});
    end
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(3))
      0: return $urandom();
      1, 2: return 32'($urandom_range(0, 2 * 11796480) - 11796480);
      default: return 32'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  task automatic add_sample(logic [31:0] yaw, logic [31:0] pitch, logic [31:0] roll);
    afp_sample_t s;
    s.yaw = yaw;
    s.pitch = pitch;
    s.roll = roll;
    sample_q.push_back(s);
  endtask

  task automatic add_random(int n);
    repeat (n) add_sample(rand_angle(), rand_angle(), rand_angle());
  endtask

  task automatic cfg_read_check(logic reg_sel);
    logic [31:0] want;
    want = {24'd0, (reg_sel == REG_DEST_ADDR) ? dest_addr_shadow : frame_id_shadow};
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {reg_sel, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    if (cfg_prdata !== want) begin
      report_mismatch($sformatf("reg %0d read %08h, want %08h", reg_sel, cfg_prdata, want));
    end
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic cfg_write(logic reg_sel, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_sel, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (reg_sel == REG_DEST_ADDR) begin
      dest_addr_shadow = value[7:0];
    end else begin
      frame_id_shadow = value[7:0];
    end
    cfg_read_check(reg_sel);
  endtask

  task automatic drain();
    @(negedge clk);
    while (sample_q.size() > 0 || in_tvalid || frame_bytes_q.size() > 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pack_frame(afp_sample_t'(in_tdata));
        frames_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= sample_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (frame_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", out_tdata, out_tlast));
        end else begin
          want_byte = frame_bytes_q.pop_front();
          if (out_tdata !== want_byte.data) begin
            report_mismatch($sformatf("frame byte %02h, want %02h", out_tdata, want_byte.data));
          end
          if (out_tlast !== want_byte.last) begin
            report_mismatch($sformatf("tlast %0b, want %0b", out_tlast, want_byte.last));
          end
          bytes_checked++;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    send_idle_pct = 6;
    recv_idle_pct = 75;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    cfg_read_check(REG_DEST_ADDR);
    cfg_read_check(REG_FRAME_ID);

    // zero registers, upper write bits set
    cfg_write(REG_DEST_ADDR, 32'hFFFF_FF00);
    cfg_write(REG_FRAME_ID, 32'hA5A5_5A00);
    add_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_sample(32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000);
    add_sample(32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_sample(32'h0000_0041, 32'hFFFF_FFBF, 32'h0000_0042);
    add_sample(32'hFFFF_FFBE, 32'h8000_0001, 32'h7FFF_0000);
    add_sample(32'h00B4_0000, 32'hFF4C_0000, 32'h0000_8000);
    add_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
    add_sample(32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC);
    add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_sample(32'h0000_0010, 32'hFFFF_FFF0, 32'hFFFF_8000);
    drain();

    cfg_write(REG_DEST_ADDR, 32'hFFFF_FFFF);
    cfg_write(REG_FRAME_ID, 32'h1234_56FF);
    add_random(RANDOM_ITEMS);
    drain();

    send_idle_pct = 75;
    recv_idle_pct = 6;
    cfg_write(REG_DEST_ADDR, $urandom());
    cfg_write(REG_FRAME_ID, $urandom());
    add_random(RANDOM_ITEMS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(REG_DEST_ADDR, $urandom());
    cfg_write(REG_FRAME_ID, $urandom());
    add_random(RANDOM_ITEMS);
    drain();
    repeat (40) @(posedge clk);

    if (frame_bytes_q.size() != 0) begin
      report_mismatch($sformatf("%0d frame bytes never arrived", frame_bytes_q.size()));
    end
    $display("Sent %0d samples and checked %0d frame bytes", frames_accepted, bytes_checked);
    $display("Covered four address/id settings and three stall patterns, %0d errors", errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/afp_pkg.sv
design/afp_front.sv
design/afp_queue.sv
design/afp_back.sv
design/attitude_frame_packer_core.sv
tb/sv/attitude_frame_packer_core_tb.sv
